@@ rtl/llss_pkg.sv @@
// Package for the least-loaded latency server select block.
// Holds default sizes, register indexes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package llss_pkg;

	localparam int DEF_NUM_SERVERS = 8;
	localparam int DEF_NUM_ISPS    = 4;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int LAT_W     = 8;
	localparam int WEIGHT_W  = LAT_W + 1;
	localparam int ISP_W     = 2;
	localparam int SIDX_W    = 3;
	localparam int MAP_W     = 16;
	localparam int MAP_SERVERS = MAP_W / ISP_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_LAT_ROWS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_ROWS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_MAP    = 2'd2;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAX,
		ST_MIN,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic max_step;
		logic min_step;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_free;
	} status_t;

endpackage

@@ rtl/llss_ctrl.sv @@
// Controller for the server select block: sequences the peak scan, the
// weight scan and the counter update. Depends on llss_pkg.
module llss_ctrl
	import llss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_op,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_QUERY) state_d = ST_MAX;
			end
			ST_MAX: begin
				if (status.idx_last) state_d = ST_MIN;
			end
			ST_MIN: begin
				if (status.idx_last) state_d = ST_UPD;
			end
			ST_UPD: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_CLEAR) cmd.clear = 1'b1;
					else cmd.load = 1'b1;
				end
			end
			ST_MAX:  cmd.max_step = 1'b1;
			ST_MIN:  cmd.min_step = 1'b1;
			ST_UPD:  cmd.update   = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/llss_datapath.sv @@
// Datapath for the server select block: configuration registers, query
// counters, scan index, peak and best-weight registers, output register.
// Depends on llss_pkg.
module llss_datapath
	import llss_pkg::*;
#(
	parameter int NUM_SERVERS = DEF_NUM_SERVERS,
	parameter int NUM_ISPS    = DEF_NUM_ISPS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic [ISP_W-1:0]      client_isp,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [SIDX_W-1:0]     server_index
);

	localparam int IW = (NUM_SERVERS > 2) ? $clog2(NUM_SERVERS) : 1;
	localparam int XW = 7;

	logic [CFG_DATA_W-1:0]  lat_low_q, lat_high_q;
	logic [MAP_W-1:0]       map_q;
	logic [COUNT_WIDTH-1:0] counts_q [NUM_SERVERS];
	logic [IW-1:0]          idx_q, best_idx_q, rd_addr;
	logic [COUNT_WIDTH-1:0] peak_q, rd_data;
	logic [WEIGHT_W-1:0]    best_w_q, weight;
	logic [ISP_W-1:0]       cisp_q, cisp_clamped, sisp_raw, sisp;
	logic [XW-1:0]          idx_ext;
	logic [LAT_W-1:0]       lat;
	logic [CFG_DATA_W-1:0]  row_word;
	logic                   idx_last, load_hit, out_valid_q;
	logic [SIDX_W-1:0]      server_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_low_q  <= '0;
			lat_high_q <= '0;
			map_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LAT_ROWS_LOW:  lat_low_q  <= wr_data;
				REG_LAT_ROWS_HIGH: lat_high_q <= wr_data;
				REG_SERVER_MAP:    map_q      <= wr_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp ISP numbers the table does not cover
	always_comb begin
		if ({1'b0, client_isp} >= 3'(NUM_ISPS)) cisp_clamped = ISP_W'(NUM_ISPS - 1);
		else cisp_clamped = client_isp;
	end

	assign idx_last = (idx_q == IW'(NUM_SERVERS - 1));
	assign rd_addr  = cmd.update ? best_idx_q : idx_q;
	assign rd_data  = counts_q[rd_addr];

	// servers past the map sit on ISP 0
	always_comb begin
		idx_ext = XW'(idx_q);
		if (idx_ext < XW'(MAP_SERVERS)) sisp_raw = map_q[{idx_ext[2:0], 1'b0} +: ISP_W];
		else sisp_raw = '0;
		if ({1'b0, sisp_raw} >= 3'(NUM_ISPS)) sisp = ISP_W'(NUM_ISPS - 1);
		else sisp = sisp_raw;
	end

	assign row_word = cisp_q[1] ? lat_high_q : lat_low_q;
	assign lat      = row_word[{cisp_q[0], sisp, 3'b000} +: LAT_W];
	assign load_hit = (peak_q != '0) && (rd_data == peak_q);
	assign weight   = {1'b0, lat} + WEIGHT_W'(load_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVERS; i++) counts_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_SERVERS; i++) counts_q[i] <= '0;
		end else if (cmd.update && rd_data != '1) begin
			counts_q[best_idx_q] <= rd_data + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.max_step || cmd.min_step) begin
			idx_q <= idx_last ? '0 : idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cisp_q <= cisp_clamped;
			peak_q <= '0;
		end else if (cmd.max_step && rd_data > peak_q) begin
			peak_q <= rd_data;
		end
		// first server seeds the running best, later ones replace on a strict win
		if (cmd.min_step && (idx_q == '0 || weight < best_w_q)) begin
			best_w_q   <= weight;
			best_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) server_index_q <= SIDX_W'(best_idx_q);
	end

	assign status.idx_last = idx_last;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign server_index    = server_index_q;

endmodule

@@ rtl/least_loaded_latency_server_select.sv @@
// Least-loaded latency server select, top level. Depends on llss_pkg,
// llss_ctrl and llss_datapath.
// A query beat is taken, then a peak scan and a weight scan run over the
// counters one server a cycle through the single counter read port, and then
// the update runs once the output register is free; the result appears
// in the output register the cycle after. A clear beat zeroes every counter.
// Reset clears the counters, the configuration registers and the controller.
module least_loaded_latency_server_select
	import llss_pkg::*;
#(
	parameter int NUM_SERVERS = DEF_NUM_SERVERS,
	parameter int NUM_ISPS    = DEF_NUM_ISPS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [1:0] client_isp
	input  logic                  s_axis_tuser,  // [0] op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [2:0] server_index
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cmd_t              cmd;
	status_t           status;
	logic [SIDX_W-1:0] server_index;

	llss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	llss_datapath #(
		.NUM_SERVERS (NUM_SERVERS),
		.NUM_ISPS    (NUM_ISPS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.client_isp   (s_axis_tdata[ISP_W-1:0]),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.server_index (server_index)
	);

	assign m_axis_tdata = {5'b0, server_index};

	// a query keeps the input side closed while it works
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
		else $error("input taken while a query is in progress");

	// a query leaves a result waiting at the end of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY
		|-> ##(2*NUM_SERVERS+2) m_axis_tvalid)
		else $error("query finished without a result beat");

	// a clear beat leaves the input side open
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_CLEAR |=> s_axis_tready)
		else $error("clear beat stalled the input");

endmodule
